// ----- rtl/core/smf_pkg.sv -----
// Shared types, constants and sorting helpers for the switching median filter.
`default_nettype none

package smf_pkg;

  // Default line-store depth and frame height limit
  localparam int SMF_MAX_WIDTH  = 2048;
  localparam int SMF_MAX_HEIGHT = 2048;

  // Configuration register width and reset values
  localparam int              SMF_CFG_W      = 12;
  localparam logic [SMF_CFG_W-1:0] SMF_WIDTH_RST  = 12'd1920;
  localparam logic [SMF_CFG_W-1:0] SMF_HEIGHT_RST = 12'd1080;

  // Configuration register indexes
  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // One packed pixel: first channel in the low byte
  typedef logic [23:0]     pix_t;
  typedef pix_t [8:0]      win_t;
  typedef logic [7:0][7:0] byte8_t;
  typedef byte8_t [2:0]    chan_set_t;

  // Input request: pixel or flush
  typedef struct packed {
    logic       action;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
  } in_req_t;

  // Output request: filtered pixel
  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic       frame_end;
  } out_req_t;

  // Compare and exchange two lanes, smaller value to the lower lane
  function automatic byte8_t cmp_swap(byte8_t v, int unsigned a, int unsigned b);
    byte8_t     r;
    logic [7:0] t;
    r = v;
    if (v[a] > v[b]) begin
      t    = r[a];
      r[a] = r[b];
      r[b] = t;
    end
    return r;
  endfunction

  // First three layers of the eight-input odd-even merge sort
  function automatic byte8_t sort_front(byte8_t v);
    byte8_t r;
    r = v;
    r = cmp_swap(r, 0, 1);
    r = cmp_swap(r, 2, 3);
    r = cmp_swap(r, 4, 5);
    r = cmp_swap(r, 6, 7);
    r = cmp_swap(r, 0, 2);
    r = cmp_swap(r, 1, 3);
    r = cmp_swap(r, 4, 6);
    r = cmp_swap(r, 5, 7);
    r = cmp_swap(r, 1, 2);
    r = cmp_swap(r, 5, 6);
    return r;
  endfunction

  // Last three layers of the eight-input odd-even merge sort
  function automatic byte8_t sort_back(byte8_t v);
    byte8_t r;
    r = v;
    r = cmp_swap(r, 0, 4);
    r = cmp_swap(r, 1, 5);
    r = cmp_swap(r, 2, 6);
    r = cmp_swap(r, 3, 7);
    r = cmp_swap(r, 2, 4);
    r = cmp_swap(r, 3, 5);
    r = cmp_swap(r, 1, 2);
    r = cmp_swap(r, 3, 4);
    r = cmp_swap(r, 5, 6);
    return r;
  endfunction

  // Truncated mean of the two middle values of a sorted set
  function automatic logic [7:0] mid_mean(byte8_t v);
    logic [8:0] s;
    s = {1'b0, v[3]} + {1'b0, v[4]};
    return s[8:1];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/switching_median_filter_3x3_core.sv -----
// Switching median filter core: line stores, 3x3 window, sort pipeline, output register.
// Throughput: one request per cycle while in_stall is low; each line store takes one read and one write per pixel.
// Path: a result passes the stage 1, stage 2 and stage 3 registers, then the output register;
// the result stream lags the input stream by one line plus one pixel.
// Reset: clears positions, window, pipeline valids and sets width 1920, height 1080.
// The line stores are not cleared; their contents never reach a result before being written.
`default_nettype none

module switching_median_filter_3x3_core #(
  parameter int MAX_WIDTH  = smf_pkg::SMF_MAX_WIDTH,
  parameter int MAX_HEIGHT = smf_pkg::SMF_MAX_HEIGHT
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  smf_pkg::in_req_t               in_data,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output smf_pkg::out_req_t              out_data,
  // configuration port
  input  wire                            cfg_we,
  input  smf_pkg::cfg_idx_t              cfg_index,
  input  wire [smf_pkg::SMF_CFG_W-1:0]   cfg_wdata
);

  import smf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT) + 2;

  // configuration
  logic [SMF_CFG_W-1:0] image_width_r, image_height_r;
  logic [WW-1:0]        w_c;
  logic [HW-1:0]        h_c;
  logic [ROW_W-1:0]     h_e;

  // stream positions
  logic [COL_W-1:0] in_column_r, in_column_nxt, out_column_r, out_column_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [WW-1:0]    in_col_p1, out_col_p1;
  logic [ROW_W-1:0] out_row_p1;

  // handshake and pipeline control
  logic acc, go, idle_flush, emit, noise_pos, last;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_free, s2_free, s3_free, out_free;
  logic s1_move, s2_move, s3_move;
  pix_t in_pix;

  // stage 1: line store read data
  pix_t mid_mem [MAX_WIDTH];
  pix_t up_mem  [MAX_WIDTH];
  pix_t mid_rd_r, up_rd_r, up_fwd_data_r, up_val;
  logic up_fwd_r;
  logic s1_emit_r, s1_noise_pos_r, s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t s1_pix_r;

  // window and stage 2
  win_t win_r, win_nxt, s2_win_r;
  logic s2_noise_pos_r, s2_last_r;
  chan_set_t nb, front;

  // stage 3
  chan_set_t s3_part_r, back;
  pix_t      s3_center_r;
  logic      s3_noise_r, s3_last_r;
  out_req_t  out_data_r, res;

  // clamp register values to the supported frame size
  always_comb begin
    if (image_width_r < SMF_CFG_W'(3)) begin
      w_c = WW'(3);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(image_width_r);
    end
    if (image_height_r < SMF_CFG_W'(3)) begin
      h_c = HW'(3);
    end else if (32'(image_height_r) > 32'(MAX_HEIGHT)) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(image_height_r);
    end
    h_e = ROW_W'(h_c);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= SMF_WIDTH_RST;
      image_height_r <= SMF_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
      endcase
    end
  end

  // stage occupancy: a stage moves when the next one is empty or moving
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s3_move  = s3_valid_r && out_free;
    s3_free  = !s3_valid_r || out_free;
    s2_move  = s2_valid_r && s3_free;
    s2_free  = !s2_valid_r || s3_free;
    s1_move  = s1_valid_r && s2_free;
    s1_free  = !s1_valid_r || s2_free;
    in_stall = !s1_free;
    acc      = in_valid && s1_free;
  end

  // request decode and position flags
  always_comb begin
    idle_flush = in_data.action && (in_row_r == '0) && (in_column_r == '0);
    go         = acc && !idle_flush;
    in_pix     = in_data.action ? '0 : {in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};
    emit       = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_column_r != '0));
    in_col_p1  = WW'(in_column_r) + WW'(1);
    out_col_p1 = WW'(out_column_r) + WW'(1);
    out_row_p1 = out_row_r + ROW_W'(1);
    noise_pos  = (out_row_r != '0) && (out_row_p1 < h_e) &&
                 (out_column_r != '0) && (out_col_p1 < w_c);
    last       = (out_col_p1 >= w_c) && (out_row_p1 >= h_e);
  end

  // advance stream positions
  always_comb begin
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    if (go) begin
      if (in_col_p1 >= w_c) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + ROW_W'(1);
      end else begin
        in_column_nxt = in_column_r + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          in_column_nxt  = '0;
          in_row_nxt     = '0;
          out_column_nxt = '0;
          out_row_nxt    = '0;
        end else if (out_col_p1 >= w_c) begin
          out_column_nxt = '0;
          out_row_nxt    = out_row_p1;
        end else begin
          out_column_nxt = out_column_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
    end else begin
      in_column_r  <= in_column_nxt;
      in_row_r     <= in_row_nxt;
      out_column_r <= out_column_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  // middle line store: read old entry, write the new pixel
  always_ff @(posedge clk) begin
    if (go) begin
      mid_rd_r              <= mid_mem[in_column_r];
      mid_mem[in_column_r]  <= in_pix;
    end
  end

  // upper line store: read on request, write back the old middle entry when stage 1 moves
  always_ff @(posedge clk) begin
    if (go) begin
      up_rd_r <= up_mem[in_column_r];
    end
    if (s1_move) begin
      up_mem[s1_col_r] <= mid_rd_r;
    end
  end

  // forward a write-back that lands on the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_fwd_r <= 1'b0;
    end else if (go) begin
      up_fwd_r <= s1_move && (s1_col_r == in_column_r);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      up_fwd_data_r <= mid_rd_r;
    end
  end

  assign up_val = up_fwd_r ? up_fwd_data_r : up_rd_r;

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (go) begin
      s1_emit_r      <= emit;
      s1_noise_pos_r <= noise_pos;
      s1_last_r      <= last;
      s1_col_r       <= in_column_r;
      s1_pix_r       <= in_pix;
    end
  end

  // shift the window left and load the new right column
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3+1]   = win_r[r*3+2];
    end
    win_nxt[2] = up_val;
    win_nxt[5] = mid_rd_r;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_move) begin
      win_r <= win_nxt;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_win_r       <= win_nxt;
      s2_noise_pos_r <= s1_noise_pos_r;
      s2_last_r      <= s1_last_r;
    end
  end

  // gather the eight neighbours per channel and run the front half of the sort
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 4; i++) begin
        nb[ch][i] = s2_win_r[i][ch*8 +: 8];
      end
      for (int i = 5; i < 9; i++) begin
        nb[ch][i-1] = s2_win_r[i][ch*8 +: 8];
      end
      front[ch] = sort_front(nb[ch]);
    end
  end

  // stage 3 payload
  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_part_r   <= front;
      s3_center_r <= s2_win_r[4];
      s3_noise_r  <= s2_noise_pos_r && (s2_win_r[4][7:0] == 8'd0);
      s3_last_r   <= s2_last_r;
    end
  end

  // finish the sort, take the mean of the middle pair, select against the center
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      back[ch] = sort_back(s3_part_r[ch]);
    end
    res.chan0_out = s3_noise_r ? mid_mean(back[0]) : s3_center_r[7:0];
    res.chan1_out = s3_noise_r ? mid_mean(back[1]) : s3_center_r[15:8];
    res.chan2_out = s3_noise_r ? mid_mean(back[2]) : s3_center_r[23:16];
    res.frame_end = s3_last_r;
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_data_r <= res;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= go;
      end
      if (s2_free) begin
        s2_valid_r <= s1_move && s1_emit_r;
      end
      if (s3_free) begin
        s3_valid_r <= s2_move;
      end
      if (out_free) begin
        out_valid_r <= s3_move;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // frame end returns every position to the frame start
  a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit && last) |=> (in_column_r == '0 && in_row_r == '0 &&
                              out_column_r == '0 && out_row_r == '0))
    else $error("positions not cleared after frame end");

  // a blocked stage keeps its request
  a_s2_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_free) |=> s2_valid_r)
    else $error("stage 2 request lost while blocked");

  // a request leaving stage 3 lands in the output register
  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    s3_move |=> out_valid_r)
    else $error("result lost between stage 3 and output");

endmodule

`default_nettype wire
